// File: hw/rtl/string_escape_encoder_unit_defines.svh
// Assertion macros shared by the verification-only files of the escape encoder.
// No dependencies; included by the checker module.
`ifndef STRING_ESCAPE_ENCODER_UNIT_DEFINES_SVH
`define STRING_ESCAPE_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("escape encoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("escape encoder check failed");

`endif

// File: hw/rtl/see_pkg.sv
// Shared types, constants and helpers of the string escape encoder.
// No dependencies; used by all encoder modules and the checker.
package see_pkg;

	localparam int CHAR_W  = 21;  // code point width
	localparam int LIMIT_W = 20;  // max_output_length width
	localparam int DATA_W  = 24;  // tdata width, whole bytes

	localparam int COUNT_BITS_DEF  = 20;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [LIMIT_W-1:0] MAX_LEN_RST  = 20'hFFFFF;
	localparam logic               QUOTE_EN_RST = 1'b1;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_CHAR  = 2'd1,
		CMD_END   = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		REG_MAX_LEN  = 1'b0,
		REG_QUOTE_EN = 1'b1
	} reg_idx_t;

	// Characters the encoder recognizes or produces.
	localparam logic [CHAR_W-1:0] CH_BEL    = 21'h00007;
	localparam logic [CHAR_W-1:0] CH_BS     = 21'h00008;
	localparam logic [CHAR_W-1:0] CH_TAB    = 21'h00009;
	localparam logic [CHAR_W-1:0] CH_LF     = 21'h0000A;
	localparam logic [CHAR_W-1:0] CH_VT     = 21'h0000B;
	localparam logic [CHAR_W-1:0] CH_FF     = 21'h0000C;
	localparam logic [CHAR_W-1:0] CH_CR     = 21'h0000D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 21'h00020;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 21'h00022;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 21'h00027;
	localparam logic [CHAR_W-1:0] CH_DOT    = 21'h0002E;
	localparam logic [CHAR_W-1:0] CH_0      = 21'h00030;
	localparam logic [CHAR_W-1:0] CH_9      = 21'h00039;
	localparam logic [CHAR_W-1:0] CH_UA     = 21'h00041;
	localparam logic [CHAR_W-1:0] CH_UF     = 21'h00046;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h0005C;
	localparam logic [CHAR_W-1:0] CH_LA     = 21'h00061;
	localparam logic [CHAR_W-1:0] CH_LB     = 21'h00062;
	localparam logic [CHAR_W-1:0] CH_LF_LTR = 21'h00066;
	localparam logic [CHAR_W-1:0] CH_LN     = 21'h0006E;
	localparam logic [CHAR_W-1:0] CH_LR     = 21'h00072;
	localparam logic [CHAR_W-1:0] CH_LT     = 21'h00074;
	localparam logic [CHAR_W-1:0] CH_LV     = 21'h00076;
	localparam logic [CHAR_W-1:0] CH_LX     = 21'h00078;

	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	// "0123456789ABCDEF": '0' sits in the top byte, so digit d is at index ~d.
	localparam logic [15:0][7:0] HEX_DIGITS = "0123456789ABCDEF";

	// Configuration as seen by the front end.
	typedef struct packed {
		logic [LIMIT_W-1:0] max_len;
		logic               quote_en;
	} cfg_t;

	// One item's worth of output characters, chars[0] goes out first.
	typedef struct packed {
		logic [3:0][CHAR_W-1:0] chars;
		logic [1:0]             last_idx;
	} job_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
		return {{(CHAR_W-8){1'b0}}, HEX_DIGITS[~d]};
	endfunction

	function automatic logic is_hex_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
			(c >= CH_LA && c <= CH_LF_LTR);
	endfunction

endpackage

// File: hw/rtl/see_front.sv
// Front end of the escape encoder: takes input beats, classifies them and
// pushes the resulting characters as one job. Depends on see_pkg.
module see_front #(
	parameter int COUNT_BITS = see_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  see_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 in_cmd,
	input  logic [see_pkg::CHAR_W-1:0] in_code,
	output logic                       push,
	output see_pkg::job_t              push_job,
	input  logic                       queue_full
);
	import see_pkg::*;

	localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

	logic                  hex_q;
	logic                  trunc_q;
	logic [COUNT_BITS-1:0] count_q;

	logic                  hex_d;
	logic                  trunc_d;
	logic [COUNT_BITS-1:0] base;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] count_d;
	logic [2:0]            n;
	logic                  at_limit;
	logic                  named;
	logic [CHAR_W-1:0]     letter;
	logic                  accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && !queue_full;
	assign at_limit = CMP_W'(count_q) >= CMP_W'(cfg.max_len);

	// Named escapes
	always_comb begin
		named  = 1'b1;
		letter = in_code;
		case (in_code)
			CH_BEL:    letter = CH_LA;
			CH_BS:     letter = CH_LB;
			CH_FF:     letter = CH_LF_LTR;
			CH_LF:     letter = CH_LN;
			CH_CR:     letter = CH_LR;
			CH_TAB:    letter = CH_LT;
			CH_VT:     letter = CH_LV;
			CH_BSLASH: letter = CH_BSLASH;
			CH_SQUOTE: letter = CH_SQUOTE;
			CH_DQUOTE: letter = CH_DQUOTE;
			default:   named  = 1'b0;
		endcase
	end

	always_comb begin
		n                 = 3'd0;
		push_job.chars    = '0;
		hex_d             = hex_q;
		trunc_d           = trunc_q;
		base              = count_q;
		unique case (cmd_t'(in_cmd))
			CMD_START: begin
				hex_d   = 1'b0;
				trunc_d = 1'b0;
				base    = '0;
				if (cfg.quote_en) begin
					push_job.chars[0] = CH_DQUOTE;
					n                 = 3'd1;
				end
			end
			CMD_CHAR: begin
				if (!trunc_q) begin
					if (at_limit) begin
						trunc_d = 1'b1;
						if (cfg.quote_en) begin
							push_job.chars = {CH_DOT, CH_DOT, CH_DOT, CH_SPACE};
							n              = 3'd4;
						end
					end else if (named) begin
						push_job.chars[0] = CH_BSLASH;
						push_job.chars[1] = letter;
						n                 = 3'd2;
						hex_d             = 1'b0;
					end else if ((hex_q && is_hex_digit(in_code)) || in_code < CH_SPACE) begin
						push_job.chars[0] = CH_BSLASH;
						push_job.chars[1] = CH_LX;
						push_job.chars[2] = hex_char(in_code[7:4]);
						push_job.chars[3] = hex_char(in_code[3:0] & NIBBLE_MASK);
						n                 = 3'd4;
						hex_d             = 1'b1;
					end else begin
						push_job.chars[0] = in_code;
						n                 = 3'd1;
						hex_d             = 1'b0;
					end
				end
			end
			CMD_END: begin
				if (!trunc_q && cfg.quote_en) begin
					push_job.chars[0] = CH_DQUOTE;
					n                 = 3'd1;
				end
			end
			default: ;  // unused command: no output, no state change
		endcase
		push_job.last_idx = 2'(n - 3'd1);
	end

	assign push = accept && (n != 3'd0);

	// Output count saturates at all ones.
	assign sum     = {1'b0, base} + (COUNT_BITS+1)'(n);
	assign count_d = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_q   <= 1'b0;
			trunc_q <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			hex_q   <= hex_d;
			trunc_q <= trunc_d;
			count_q <= count_d;
		end
	end

endmodule

// File: hw/rtl/see_queue.sv
// Short job queue between the encoder front and back ends.
// Depends on see_pkg for the job type.
module see_queue #(
	parameter int DEPTH = see_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  see_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output see_pkg::job_t pop_job,
	output logic          empty
);
	import see_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/see_back.sv
// Back end of the escape encoder: walks one job a character per beat into
// the output register. Depends on see_pkg.
module see_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  see_pkg::job_t              pop_job,
	input  logic                       empty,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [see_pkg::CHAR_W-1:0] out_char,
	output logic                       out_last
);
	import see_pkg::*;

	job_t              job_q;
	logic              job_vld_q;
	logic [1:0]        idx_q;
	logic              out_vld_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic load;
	logic job_done;

	assign load     = job_vld_q && (!out_vld_q || out_ready);
	assign job_done = load && (idx_q == job_q.last_idx);
	assign pop      = !empty && (!job_vld_q || job_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				job_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (job_done) begin
				job_vld_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (load) begin
			char_q <= job_q.chars[idx_q];
			last_q <= job_done;
		end
	end

	assign out_valid = out_vld_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

// File: hw/rtl/string_escape_encoder_unit.sv
// Top level of the string escape encoder: config registers, front end,
// job queue and back end. Depends on see_pkg, see_front, see_queue, see_back.
//
// Usage:
//  - Input stream (s_*): one beat per command. s_tuser carries the command
//    (start, character, end); s_tdata carries the code point.
//  - Output stream (m_*): one escaped character per beat; m_tlast marks the
//    final character produced by one input beat. Input beats that produce
//    nothing (dropped characters, unused command) give no output beat.
//  - Config (cfg_*): index 0 writes max_output_length, index 1 writes
//    quote_enable. Always ready; write only while the stream is idle.
//  - Path: an accepted input beat reaches the output through the queue
//    write, then the job load, then the output register.
//  - Throughput: the output side moves one character per cycle while m_tready
//    is high; an item yields 1 to 4 characters, and the front end takes one
//    item per cycle while the job queue has room.
//  - Reset (arst_n low): queue and output empty, string state cleared,
//    max_output_length = all ones, quote_enable = 1.
//  - Output stall: the front end keeps accepting until the job queue fills,
//    then drops s_tready; the held output beat stays stable.
module string_escape_encoder_unit #(
	parameter int COUNT_BITS  = see_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = see_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [see_pkg::LIMIT_W-1:0] cfg_data,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [see_pkg::DATA_W-1:0]  s_tdata,   // [20:0] code_point, [23:21] zero
	input  logic [1:0]                  s_tuser,   // [1:0] cmd
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [see_pkg::DATA_W-1:0]  m_tdata,   // [20:0] out_char, [23:21] zero
	output logic                        m_tlast    // last_in_run
);
	import see_pkg::*;

	cfg_t              cfg_q;
	logic              push;
	job_t              push_job;
	logic              queue_full;
	logic              pop;
	job_t              pop_job;
	logic              queue_empty;
	logic [CHAR_W-1:0] out_char;

	// Config registers; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len  <= MAX_LEN_RST;
			cfg_q.quote_en <= QUOTE_EN_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAX_LEN:  cfg_q.max_len  <= cfg_data;
				REG_QUOTE_EN: cfg_q.quote_en <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front end: classification and string state
	see_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_code   (s_tdata[CHAR_W-1:0]),
		.push      (push),
		.push_job  (push_job),
		.queue_full(queue_full)
	);

	// Decouples classification from output serialization
	see_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (queue_full),
		.pop     (pop),
		.pop_job (pop_job),
		.empty   (queue_empty)
	);

	// Back end: one character per beat
	see_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_job  (pop_job),
		.empty    (queue_empty),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_char (out_char),
		.out_last (m_tlast)
	);

	assign m_tdata = {{(DATA_W-CHAR_W){1'b0}}, out_char};

endmodule

// File: hw/rtl/see_checker.sv
// Port-level checks of the escape encoder, bound to the top level.
// Depends on see_pkg and string_escape_encoder_unit_defines.svh.
`include "string_escape_encoder_unit_defines.svh"

module see_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [see_pkg::DATA_W-1:0]  m_tdata,
	input logic                        m_tlast
);
	import see_pkg::*;

	logic [CHAR_W-1:0] oc;
	logic              oc_hex;

	assign oc     = m_tdata[CHAR_W-1:0];
	assign oc_hex = (oc >= CH_0 && oc <= CH_9) || (oc >= CH_UA && oc <= CH_UF);

	// A stalled output beat holds.
	`SEE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// Padding above the character stays zero.
	`SEE_ASSERT_NOW(a_out_pad, clk, arst_n, m_tvalid,
		m_tdata[DATA_W-1:CHAR_W] == '0)

	// Only escape lead-ins, hex digits or the truncation marker come before the last beat.
	`SEE_ASSERT_NOW(a_mid_char, clk, arst_n, m_tvalid && !m_tlast,
		oc == CH_BSLASH || oc == CH_LX || oc_hex || oc == CH_SPACE || oc == CH_DOT)

	// The input only backs up right after an input beat was offered.
	`SEE_ASSERT_NOW(a_ready_fall, clk, arst_n, $fell(s_tready), $past(s_tvalid))

endmodule

bind string_escape_encoder_unit see_checker u_see_checker (.*);
